FILE: hw/rtl/fqsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqsr_pkg
// Shared types and constants for the fifo queue with search and reverse.
// ----------------------------------------------------------------------------
package fqsr_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int VALUE_BITS_DEF = 32;
    localparam int FIELD_BITS     = 32;
    localparam int COUNT_BITS     = 5;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_POP     = 2'd1,
        OP_SEARCH  = 2'd2,
        OP_REVERSE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_op                           opcode;
        logic signed [FIELD_BITS-1:0]  value;
    } t_in_item;

    typedef struct packed {
        t_status                       status;
        logic signed [FIELD_BITS-1:0]  value_out;
        logic                          found;
        logic [COUNT_BITS-1:0]         count;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DRAIN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic accept;
        logic scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

FILE: hw/rtl/fqsr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqsr_ctrl
// Sequencer: accepts one item, runs the read or scan, then commits the result.
// ----------------------------------------------------------------------------
module fqsr_ctrl
    import fqsr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_stall,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (i_sts.op == OP_SEARCH) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        o_cmd      = '0;
        case (r_state)
            S_IDLE:  o_cmd.accept = i_in_valid;
            S_SCAN:  o_cmd.scan   = 1'b1;
            S_FIN:   o_cmd.commit = i_sts.out_free;
            default: o_cmd        = '0;
        endcase
    end

endmodule

FILE: hw/rtl/fqsr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqsr_dp
// Datapath: entry ring memory, end pointers, scan unit and result register.
// ----------------------------------------------------------------------------
module fqsr_dp
    import fqsr_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  logic      i_out_stall,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX  = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] idx);
        ring_inc = (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IW-1:0] ring_dec(input logic [IW-1:0] idx);
        ring_dec = (idx == '0) ? LAST_IDX : idx - 1'b1;
    endfunction

    logic [VALUE_BITS-1:0] r_mem [DEPTH];
    logic [VALUE_BITS-1:0] r_rdata;

    logic [IW-1:0] r_front;
    logic [IW-1:0] r_back;
    logic [CW-1:0] r_count;
    logic          r_rev;

    t_op                   r_op;
    logic [VALUE_BITS-1:0] r_val;
    logic [VALUE_BITS-1:0] w_in_val;

    logic [CW-1:0] r_k;
    logic [IW-1:0] r_idx;
    logic          r_cmp_v;
    logic          r_found;

    logic          r_out_valid;
    t_out_item     r_out_item;

    logic [IW-1:0]         w_rd_addr;
    logic [IW-1:0]         w_wr_addr;
    logic                  w_wr_en;
    logic [FIELD_BITS-1:0] w_rd_field;
    logic [COUNT_BITS-1:0] w_count_field;

    logic [IW-1:0] n_front;
    logic [IW-1:0] n_back;
    logic [CW-1:0] n_count;
    logic          n_rev;
    t_out_item     n_out_item;

    assign w_in_val      = VALUE_BITS'($unsigned(i_in_item.value));
    assign w_rd_field    = FIELD_BITS'(r_rdata);
    assign w_count_field = COUNT_BITS'(n_count);

    assign w_rd_addr = (r_op == OP_POP) ? (r_rev ? ring_dec(r_back) : r_front) : r_idx;

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[w_rd_addr];
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= r_val;
        end
    end

    always_comb begin
        n_front    = r_front;
        n_back     = r_back;
        n_count    = r_count;
        n_rev      = r_rev;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_back;
        n_out_item = '0;
        n_out_item.status = ST_OK;
        case (r_op)
            OP_PUSH: begin
                if (r_count == FULL_CNT) begin
                    n_out_item.status = ST_FULL;
                end else begin
                    w_wr_en = i_cmd.commit;
                    n_count = r_count + 1'b1;
                    if (r_rev) begin
                        n_front   = ring_dec(r_front);
                        w_wr_addr = ring_dec(r_front);
                    end else begin
                        n_back    = ring_inc(r_back);
                    end
                end
            end
            OP_POP: begin
                if (r_count == '0) begin
                    n_out_item.status = ST_EMPTY;
                end else begin
                    n_out_item.value_out = w_rd_field;
                    n_count = r_count - 1'b1;
                    if (r_rev) begin
                        n_back  = ring_dec(r_back);
                    end else begin
                        n_front = ring_inc(r_front);
                    end
                end
            end
            OP_SEARCH: begin
                n_out_item.found = r_found;
            end
            OP_REVERSE: begin
                if (r_count != '0) begin
                    n_rev = !r_rev;
                end
            end
            default: begin
                n_out_item = '0;
            end
        endcase
        n_out_item.count = w_count_field;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_back      <= '0;
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_out_valid <= 1'b0;
            r_cmp_v     <= 1'b0;
        end else begin
            r_cmp_v <= i_cmd.scan && (r_k != r_count);
            if (i_cmd.commit) begin
                r_front     <= n_front;
                r_back      <= n_back;
                r_count     <= n_count;
                r_rev       <= n_rev;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_in_item.opcode;
            r_val   <= w_in_val;
            r_k     <= '0;
            r_idx   <= r_front;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.scan && (r_k != r_count)) begin
                r_k   <= r_k + 1'b1;
                r_idx <= ring_inc(r_idx);
            end
            if (r_cmp_v && (r_rdata == r_val)) begin
                r_found <= 1'b1;
            end
        end
        if (i_cmd.commit) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.scan_done = (r_k == r_count);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out_item      = r_out_item;

endmodule

FILE: hw/rtl/fifo_queue_with_search_reverse_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_search_reverse_unit
// Push, pop, reverse: each item runs decode, registered ring read and commit.
// Search: one stored entry is compared per cycle through the single memory
// read port, until every stored entry has been compared.
// The result register lets the next item start while a result waits.
// Synchronous active-low reset empties the queue; entry contents are kept.
// ----------------------------------------------------------------------------
module fifo_queue_with_search_reverse_unit
    import fqsr_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_cmd w_cmd;
    t_sts w_sts;
    t_cmd w_cmd_route;

    fqsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    assign w_cmd_route = w_cmd;

    fqsr_dp #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd_route),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: dv/fifo_queue_with_search_reverse_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_search_reverse_unit_tb
// Drives push, pop, search and reverse items into the queue and checks every
// result against a ring-buffer predictor kept in step with accepted items.
// Directed cases cover the empty and full queue, extreme values and the
// reversed direction. Random phases then fill, drain and mix the queue.
// Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module fifo_queue_with_search_reverse_unit_tb;
    import fqsr_pkg::*;

    localparam int RING_SIZE    = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 700;
    localparam int PRINT_LIMIT  = 50;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    logic signed [FIELD_BITS-1:0] model_ring [RING_SIZE];
    int        model_front    = 0;
    int        model_back     = 0;
    int        model_count    = 0;
    bit        model_reversed = 1'b0;

    t_out_item expected_results [$];
    int        err_count  = 0;
    bit        no_idle    = 1'b0;
    int        stall_left = 0;

    fifo_queue_with_search_reverse_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int ring_next(input int idx);
        return (idx + 1) % RING_SIZE;
    endfunction

    function automatic int ring_prev(input int idx);
        return (idx + RING_SIZE - 1) % RING_SIZE;
    endfunction

    // advances the queue state by one item and returns its result
    function automatic t_out_item queue_model_step(input t_op op,
                                                   input logic signed [FIELD_BITS-1:0] value);
        t_out_item res;
        int        idx;
        res        = '0;
        res.status = ST_OK;
        case (op)
            OP_PUSH: begin
                if (model_count >= RING_SIZE) begin
                    res.status = ST_FULL;
                end else if (!model_reversed) begin
                    model_ring[model_back] = value;
                    model_back  = ring_next(model_back);
                    model_count++;
                end else begin
                    model_front = ring_prev(model_front);
                    model_ring[model_front] = value;
                    model_count++;
                end
            end
            OP_POP: begin
                if (model_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (!model_reversed) begin
                    res.value_out = model_ring[model_front];
                    model_front   = ring_next(model_front);
                    model_count--;
                end else begin
                    model_back    = ring_prev(model_back);
                    res.value_out = model_ring[model_back];
                    model_count--;
                end
            end
            OP_SEARCH: begin
                idx = model_front;
                for (int k = 0; k < model_count; k++) begin
                    if (model_ring[idx] == value) res.found = 1'b1;
                    idx = ring_next(idx);
                end
            end
            default: begin
                if (model_count != 0) model_reversed = !model_reversed;
            end
        endcase
        res.count = model_count[COUNT_BITS-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [FIELD_BITS-1:0] got,
                                   input logic [FIELD_BITS-1:0] want);
        if (err_count < PRINT_LIMIT)
            $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        err_count++;
    endtask

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [FIELD_BITS-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // value held somewhere in the queue, so that searches hit
    function automatic logic signed [FIELD_BITS-1:0] pick_stored_value();
        int k;
        if (model_count == 0) return pick_value();
        k = $urandom_range(0, model_count - 1);
        return model_ring[(model_front + k) % RING_SIZE];
    endfunction

    task automatic send_item(input t_op op, input logic signed [FIELD_BITS-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= '{opcode: op, value: value};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.push_back(queue_model_step(op, value));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // result checker and receiver stall generator
    always @(posedge i_clk) begin
        t_out_item want;
        int        r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected item", o_out_item.value_out, '0);
            end else begin
                want = expected_results.pop_front();
                if (o_out_item.status !== want.status)
                    report_mismatch("status", o_out_item.status, want.status);
                if (o_out_item.value_out !== want.value_out)
                    report_mismatch("value_out", o_out_item.value_out, want.value_out);
                if (o_out_item.found !== want.found)
                    report_mismatch("found", o_out_item.found, want.found);
                if (o_out_item.count !== want.count)
                    report_mismatch("count", o_out_item.count, want.count);
            end
        end
        if (no_idle) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b1;
                stall_left = (r < 93) ? $urandom_range(0, 2) : $urandom_range(8, 40);
            end
        end
    end

    task automatic test_empty_queue();
        send_item(OP_POP, $urandom);
        send_item(OP_SEARCH, 32'sh0);
        send_item(OP_REVERSE, $urandom);
    endtask

    task automatic test_full_queue();
        logic signed [FIELD_BITS-1:0] fill [7];
        fill = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1,
                 32'sh5555_5555, 32'shaaaa_aaaa, 32'sd1};
        for (int k = 0; k < RING_SIZE; k++)
            send_item(OP_PUSH, (k < 7) ? fill[k] : $urandom);
        send_item(OP_PUSH, 32'sh1234_5678);
        send_item(OP_SEARCH, 32'sh7fff_ffff);
        send_item(OP_SEARCH, 32'sh7fff_fffe);
    endtask

    task automatic test_reverse_order();
        logic signed [FIELD_BITS-1:0] v;
        v = $urandom;
        send_item(OP_REVERSE, $urandom);
        send_item(OP_POP, $urandom);
        send_item(OP_PUSH, v);
        send_item(OP_SEARCH, v);
    endtask

    task automatic test_random_traffic(input int n_items);
        int  sent;
        int  phase_len;
        int  mode;
        int  r;
        int  w_push;
        int  w_pop;
        int  w_search;
        bit  paused;
        t_op op;
        logic signed [FIELD_BITS-1:0] v;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            phase_len = $urandom_range(15, 60);
            mode      = $urandom_range(0, 2);
            no_idle   = ($urandom_range(0, 4) == 0);
            // fill, drain or mixed phase
            case (mode)
                0:       begin w_push = 60; w_pop = 75; w_search = 90; end
                1:       begin w_push = 15; w_pop = 75; w_search = 90; end
                default: begin w_push = 30; w_pop = 60; w_search = 88; end
            endcase
            for (int k = 0; k < phase_len && sent < n_items; k++) begin
                r = $urandom_range(0, 99);
                if (r < w_push)        op = OP_PUSH;
                else if (r < w_pop)    op = OP_POP;
                else if (r < w_search) op = OP_SEARCH;
                else                   op = OP_REVERSE;
                if (op == OP_SEARCH && $urandom_range(0, 1) == 1) v = pick_stored_value();
                else                                               v = pick_value();
                send_item(op, v);
                sent++;
            end
            if (!paused && sent >= n_items / 2) begin
                paused = 1'b1;
                wait_drained();
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_queue();
        test_full_queue();
        test_reverse_order();
        test_random_traffic(RANDOM_ITEMS);
        wait_drained();
        repeat (RING_SIZE + 8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
